// ===== hw/rtl/lsfr_pkg.sv =====
package lsfr_pkg;

   // Frame limits and field widths
   localparam int MaxDataBytes = 8;
   localparam int IdWidth      = 6;
   localparam int LenWidth     = 4;
   localparam int ByteWidth    = 8;
   localparam int IndexWidth   = 3;
   localparam int CsrDataWidth = 6;
   localparam int CsrIndexWidth = 1;

   // Receive phase codes
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DATA = 2'd1;
   localparam logic [1:0] PH_CSUM = 2'd2;

   // Result kinds
   localparam logic KIND_DATA      = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   // Register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_SLAVE_ID     = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_FRAME_LENGTH = 1'b1;

   // Register reset values
   localparam logic [IdWidth-1:0]  SlaveIdReset     = 6'd1;
   localparam logic [LenWidth-1:0] FrameLengthReset = 4'd4;

   typedef struct packed {
      logic [1:0]            phase;
      logic [IndexWidth-1:0] data_count;
      logic [ByteWidth-1:0]  running_sum;
   } frame_state_type;

   typedef struct packed {
      logic                  produce;
      logic                  kind;
      logic [ByteWidth-1:0]  data_byte;
      logic [IndexWidth-1:0] byte_index;
      logic                  checksum_ok;
   } frame_result_type;

   // Identifier with parity: P0 even over bits 0..2, P1 inverted over 1,3,4,5
   function automatic logic [ByteWidth-1:0] protected_id(input logic [IdWidth-1:0] id);
      logic p0;
      logic p1;
      p0 = id[0] ^ id[1] ^ id[2];
      p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
      return {p1, p0, id};
   endfunction

endpackage

// ===== hw/rtl/lsfr_channels.sv =====
interface lsfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lsfr_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic [2:0] byte_index;
   logic       checksum_ok;

   modport source (output valid, output kind, output data_byte, output byte_index,
                   output checksum_ok, input ready);
   modport sink   (input valid, input kind, input data_byte, input byte_index,
                   input checksum_ok, output ready);
endinterface

// ===== hw/rtl/lsfr_frame_step.sv =====
module lsfr_frame_step (
   input  lsfr_pkg::frame_state_type               state,
   input  logic [lsfr_pkg::ByteWidth-1:0]          rx_byte,
   input  logic [lsfr_pkg::IdWidth-1:0]            slave_id,
   input  logic [lsfr_pkg::LenWidth-1:0]           frame_length,
   output lsfr_pkg::frame_state_type               state_next,
   output lsfr_pkg::frame_result_type              result
);

   logic [lsfr_pkg::LenWidth-1:0]  eff_length;
   logic [lsfr_pkg::LenWidth-1:0]  count_next;
   logic [lsfr_pkg::ByteWidth:0]   sum_wide;
   logic [lsfr_pkg::ByteWidth-1:0] sum_next;

   // Clamp frame length into 1..MaxDataBytes
   always_comb begin
      priority if (frame_length == '0) begin
         eff_length = lsfr_pkg::LenWidth'(1);
      end else if (frame_length > lsfr_pkg::LenWidth'(lsfr_pkg::MaxDataBytes)) begin
         eff_length = lsfr_pkg::LenWidth'(lsfr_pkg::MaxDataBytes);
      end else begin
         eff_length = frame_length;
      end
   end

   // Add with end-around carry
   assign sum_wide   = {1'b0, state.running_sum} + {1'b0, rx_byte};
   assign sum_next   = sum_wide[lsfr_pkg::ByteWidth-1:0] +
                       lsfr_pkg::ByteWidth'(sum_wide[lsfr_pkg::ByteWidth]);
   assign count_next = {1'b0, state.data_count} + lsfr_pkg::LenWidth'(1);

   // Advance the frame by one byte
   always_comb begin
      result.produce     = 1'b0;
      result.kind        = lsfr_pkg::KIND_DATA;
      result.data_byte   = '0;
      result.byte_index  = '0;
      result.checksum_ok = 1'b0;
      state_next.phase       = lsfr_pkg::PH_IDLE;
      state_next.data_count  = '0;
      state_next.running_sum = '0;
      unique case (state.phase)
         lsfr_pkg::PH_DATA: begin
            result.produce         = 1'b1;
            result.data_byte       = rx_byte;
            result.byte_index      = state.data_count;
            state_next.running_sum = sum_next;
            state_next.data_count  = count_next[lsfr_pkg::IndexWidth-1:0];
            state_next.phase       = (count_next >= eff_length) ? lsfr_pkg::PH_CSUM
                                                                 : lsfr_pkg::PH_DATA;
         end
         lsfr_pkg::PH_CSUM: begin
            result.produce     = 1'b1;
            result.kind        = lsfr_pkg::KIND_FRAME_END;
            result.checksum_ok = (rx_byte == ~state.running_sum);
         end
         default: begin
            // idle, or an unused code: look for our identifier
            if (rx_byte == lsfr_pkg::protected_id(slave_id)) begin
               state_next.phase = lsfr_pkg::PH_DATA;
            end
         end
      endcase
   end

endmodule

// ===== hw/rtl/lin_slave_frame_receiver.sv =====
// Channel | Direction | Payload                                      | Transfer
// req     | in        | rx_byte[7:0]                                 | valid & ready
// rsp     | out       | kind, data_byte[7:0], byte_index[2:0], cks_ok | valid & ready
// csr     | in        | csr_index[0], csr_wdata[5:0]                 | csr_we
//
// One byte per cycle sustained while results are taken: a byte waits in the input register,
// then the frame step updates the state and loads the result register.
// A byte's result is then offered from the result register; idle-phase bytes give none.
// Reset (synchronous, active high) restores slave_id 1, frame_length 4, idle phase.
// A stalled result holds the pipe only while both registers are full.
module lin_slave_frame_receiver (
   input  logic                                  clock,
   input  logic                                  reset,
   lsfr_req_if.sink                              req,
   lsfr_rsp_if.source                            rsp,
   input  logic                                  csr_we,
   input  logic [lsfr_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [lsfr_pkg::CsrDataWidth-1:0]     csr_wdata
);

   logic [lsfr_pkg::IdWidth-1:0]   slave_id_ff;
   logic [lsfr_pkg::LenWidth-1:0]  frame_length_ff;
   logic                           in_valid_ff;
   logic [lsfr_pkg::ByteWidth-1:0] in_byte_ff;
   lsfr_pkg::frame_state_type      state_ff;
   lsfr_pkg::frame_state_type      state_in;
   lsfr_pkg::frame_result_type     result_in;
   logic                           out_valid_ff;
   logic                           out_kind_ff;
   logic [lsfr_pkg::ByteWidth-1:0] out_byte_ff;
   logic [lsfr_pkg::IndexWidth-1:0] out_index_ff;
   logic                           out_ok_ff;
   logic                           advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_id_ff     <= lsfr_pkg::SlaveIdReset;
         frame_length_ff <= lsfr_pkg::FrameLengthReset;
      end else if (csr_we) begin
         unique case (csr_index)
            lsfr_pkg::CSR_SLAVE_ID:     slave_id_ff <= csr_wdata;
            lsfr_pkg::CSR_FRAME_LENGTH: frame_length_ff <= csr_wdata[lsfr_pkg::LenWidth-1:0];
            default: ;
         endcase
      end
   end

   // Move the held byte on when the result slot is free or draining
   assign advance   = in_valid_ff & (~out_valid_ff | rsp.ready);
   assign req.ready = ~in_valid_ff | advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.rx_byte;
      end
   end

   lsfr_frame_step u_step (
      .state        (state_ff),
      .rx_byte      (in_byte_ff),
      .slave_id     (slave_id_ff),
      .frame_length (frame_length_ff),
      .state_next   (state_in),
      .result       (result_in)
   );

   // Frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= lsfr_pkg::PH_IDLE;
         state_ff.data_count  <= '0;
         state_ff.running_sum <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= result_in.produce;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_in.produce) begin
         out_kind_ff  <= result_in.kind;
         out_byte_ff  <= result_in.data_byte;
         out_index_ff <= result_in.byte_index;
         out_ok_ff    <= result_in.checksum_ok;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.kind        = out_kind_ff;
   assign rsp.data_byte   = out_byte_ff;
   assign rsp.byte_index  = out_index_ff;
   assign rsp.checksum_ok = out_ok_ff;

endmodule
